/* rtl/edt_pkg.sv */
// ----------------------------------------------------------------------------
// edt_pkg - shared types and constants for the timestamp-to-DOS converter
// Holds the pipeline stage map, the reciprocal constants used for the
// constant divisions and the structs passed between the pipeline sections.
// ----------------------------------------------------------------------------
package edt_pkg;

  // Pipeline stage map. Stage 0 and the output stage live in the top level.
  localparam int unsigned NUM_STAGES   = 12;
  localparam int unsigned ST_UNIX      = 0;
  localparam int unsigned ST_SPLIT_LO  = 1;
  localparam int unsigned SPLIT_STAGES = 3;
  localparam int unsigned ST_CIV_LO    = 4;
  localparam int unsigned CIV_STAGES   = 7;
  localparam int unsigned ST_OUT       = 11;

  // Seconds between 1900-01-01 and 1970-01-01.
  localparam logic [31:0] EPOCH_GAP = 32'd2208988800;
  localparam logic signed [16:0] SECS_PER_HOUR_S = 17'sd3600;

  // Reciprocals: floor(x / d) == (x * ceil(2^k / d)) >> k for x < 2^n when
  // k = n + ceil(log2(d)).
  localparam int unsigned DAY_SHIFT = 36;   // 86400 = 128 * 675, x < 2^26
  localparam logic [26:0] DAY_RECIP = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
  localparam int unsigned Q1460_SHIFT = 29; // x < 2^18
  localparam logic [18:0] Q1460_RECIP = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam int unsigned Q365_SHIFT = 27;  // x < 2^18
  localparam logic [18:0] Q365_RECIP = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam int unsigned Q153_SHIFT = 19;  // x < 2^11
  localparam logic [11:0] Q153_RECIP = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam int unsigned Q3600_SHIFT = 29; // x < 2^17
  localparam logic [17:0] Q3600_RECIP = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam int unsigned Q60_SHIFT = 18;   // x < 2^12
  localparam logic [12:0] Q60_RECIP = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

  // Civil calendar constants (days counted from 1970-01-01).
  localparam logic [15:0] ERA5_FIRST_DAY = 16'd11017;   // 2000-03-01
  localparam logic [17:0] ERA4_DOE_BIAS  = 18'd135080;
  localparam logic [17:0] DAYS_PER_CENT  = 18'd36524;
  localparam logic [17:0] LAST_ERA_DAY   = 18'd146096;
  localparam logic [11:0] DOS_FIRST_YEAR = 12'd1980;
  localparam logic [11:0] DOS_LAST_YEAR  = 12'd2107;

  typedef struct packed {
    logic        neg;
    logic [15:0] days;
    logic [16:0] sod;
  } split_t;

  typedef struct packed {
    logic       oor;
    logic [6:0] year_off;
    logic [3:0] month;
    logic [4:0] day;
  } date_t;

  // Day of a March-based year on which month index mp begins.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

/* rtl/edt_split.sv */
// ----------------------------------------------------------------------------
// edt_split - offset adjust and day / second-of-day split
// Adds the hour offset and divides the adjusted time by 86400 over three
// stages using a reciprocal multiply.
// ----------------------------------------------------------------------------
module edt_split (
  input  logic                                 clk_i,
  input  logic [edt_pkg::SPLIT_STAGES-1:0]     en_i,
  input  logic [31:0]                          unix_i,
  input  logic signed [16:0]                   offs_i,
  output edt_pkg::split_t                      split_o
);

  logic signed [33:0] adj;
  logic [32:0]        t1_q;
  logic               neg1_q;
  logic [52:0]        prod;
  logic [32:0]        t2_q;
  logic [15:0]        q2_q;
  logic               neg2_q;
  logic [25:0]        rem;
  edt_pkg::split_t    split_q;

  assign adj  = $signed({2'b00, unix_i}) + 34'(offs_i);
  assign prod = 53'(t1_q[32:7]) * 53'(edt_pkg::DAY_RECIP);
  assign rem  = t2_q[32:7] - 26'(q2_q) * 26'd675;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      t1_q   <= adj[32:0];
      neg1_q <= adj[33];
    end
    if (en_i[1]) begin
      t2_q   <= t1_q;
      q2_q   <= prod[edt_pkg::DAY_SHIFT +: 16];
      neg2_q <= neg1_q;
    end
    if (en_i[2]) begin
      split_q.neg  <= neg2_q;
      split_q.days <= q2_q;
      split_q.sod  <= {rem[9:0], t2_q[6:0]};
    end
  end

  assign split_o = split_q;

endmodule

/* rtl/edt_tod.sv */
// ----------------------------------------------------------------------------
// edt_tod - time of day to DOS time word
// Splits the second of the day into hours, minutes and seconds and packs
// the DOS time word, then delays it to line up with the date section.
// ----------------------------------------------------------------------------
module edt_tod (
  input  logic                               clk_i,
  input  logic [edt_pkg::CIV_STAGES-1:0]     en_i,
  input  logic [16:0]                        sod_i,
  output logic [15:0]                        time_word_o
);

  logic [34:0] prod_h;
  logic [16:0] sod4_q;
  logic [4:0]  hh4_q;
  logic [11:0] rem5_q;
  logic [4:0]  hh5_q;
  logic [24:0] prod_m;
  logic [11:0] rem6_q;
  logic [5:0]  mm6_q;
  logic [4:0]  hh6_q;
  logic [5:0]  ss;
  logic [15:0] word7_q;
  logic [15:0] word8_q;
  logic [15:0] word9_q;
  logic [15:0] word10_q;

  assign prod_h = 35'(sod_i) * 35'(edt_pkg::Q3600_RECIP);
  assign prod_m = 25'(rem5_q) * 25'(edt_pkg::Q60_RECIP);
  assign ss     = 6'(rem6_q - 12'(mm6_q) * 12'd60);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sod4_q <= sod_i;
      hh4_q  <= prod_h[edt_pkg::Q3600_SHIFT +: 5];
    end
    if (en_i[1]) begin
      rem5_q <= 12'(sod4_q - 17'(hh4_q) * 17'd3600);
      hh5_q  <= hh4_q;
    end
    if (en_i[2]) begin
      rem6_q <= rem5_q;
      mm6_q  <= prod_m[edt_pkg::Q60_SHIFT +: 6];
      hh6_q  <= hh5_q;
    end
    if (en_i[3]) begin
      word7_q <= {hh6_q, mm6_q, ss[5:1]};
    end
    if (en_i[4]) begin
      word8_q <= word7_q;
    end
    if (en_i[5]) begin
      word9_q <= word8_q;
    end
    if (en_i[6]) begin
      word10_q <= word9_q;
    end
  end

  assign time_word_o = word10_q;

endmodule

/* rtl/edt_civil.sv */
// ----------------------------------------------------------------------------
// edt_civil - day count to Gregorian date
// Converts days since 1970 into year, month and day with the era / year of
// era method, at most one constant division per stage, and checks the DOS range.
// ----------------------------------------------------------------------------
module edt_civil (
  input  logic                               clk_i,
  input  logic [edt_pkg::CIV_STAGES-1:0]     en_i,
  input  logic [15:0]                        days_i,
  input  logic                               neg_i,
  output edt_pkg::date_t                     date_o
);

  logic [17:0]    doe4_d;
  logic [17:0]    doe4_q;
  logic           era4_q, neg4_q;
  logic [36:0]    prod_a;
  logic [17:0]    doe5_q;
  logic [6:0]     a5_q;
  logic [2:0]     b5_d, b5_q;
  logic           c5_q, era5_q, neg5_q;
  logic [17:0]    n6_q, doe6_q;
  logic           era6_q, neg6_q;
  logic [36:0]    prod_y;
  logic [8:0]     yoe7_q;
  logic [17:0]    doe7_q;
  logic           era7_q, neg7_q;
  logic [1:0]     c100;
  logic [17:0]    base;
  logic [8:0]     doy8_q, yoe8_q;
  logic           era8_q, neg8_q;
  logic [10:0]    mval;
  logic [22:0]    prod_m;
  logic [3:0]     mp9_q;
  logic [8:0]     doy9_q, yoe9_q;
  logic           era9_q, neg9_q;
  logic [11:0]    year;
  edt_pkg::date_t date_d, date_q;

  // Days before 2000-03-01 belong to the era starting 1600-03-01.
  assign doe4_d = (days_i < edt_pkg::ERA5_FIRST_DAY) ?
                  18'(days_i) + edt_pkg::ERA4_DOE_BIAS :
                  18'(days_i) - 18'(edt_pkg::ERA5_FIRST_DAY);

  assign prod_a = 37'(doe4_q) * 37'(edt_pkg::Q1460_RECIP);

  always_comb begin
    if (doe4_q >= edt_pkg::LAST_ERA_DAY) begin
      b5_d = 3'd4;
    end else if (doe4_q >= 18'(3 * edt_pkg::DAYS_PER_CENT)) begin
      b5_d = 3'd3;
    end else if (doe4_q >= 18'(2 * edt_pkg::DAYS_PER_CENT)) begin
      b5_d = 3'd2;
    end else if (doe4_q >= edt_pkg::DAYS_PER_CENT) begin
      b5_d = 3'd1;
    end else begin
      b5_d = 3'd0;
    end
  end

  assign prod_y = 37'(n6_q) * 37'(edt_pkg::Q365_RECIP);

  always_comb begin
    if (yoe7_q >= 9'd300) begin
      c100 = 2'd3;
    end else if (yoe7_q >= 9'd200) begin
      c100 = 2'd2;
    end else if (yoe7_q >= 9'd100) begin
      c100 = 2'd1;
    end else begin
      c100 = 2'd0;
    end
  end

  assign base   = 18'(yoe7_q) * 18'd365 + 18'(yoe7_q[8:2]) - 18'(c100);
  assign mval   = 11'(doy8_q) * 11'd5 + 11'd2;
  assign prod_m = 23'(mval) * 23'(edt_pkg::Q153_RECIP);

  // Months ten and eleven of a March-based year are January and February
  // of the following calendar year.
  always_comb begin
    year = 12'(yoe9_q) + (era9_q ? 12'd2000 : 12'd1600) + 12'(mp9_q >= 4'd10);
    date_d.day      = 5'(doy9_q - edt_pkg::month_start(mp9_q) + 9'd1);
    date_d.month    = (mp9_q < 4'd10) ? mp9_q + 4'd3 : mp9_q - 4'd9;
    date_d.year_off = 7'(year - edt_pkg::DOS_FIRST_YEAR);
    date_d.oor      = neg9_q || (year < edt_pkg::DOS_FIRST_YEAR) ||
                      (year > edt_pkg::DOS_LAST_YEAR);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      doe4_q <= doe4_d;
      era4_q <= (days_i >= edt_pkg::ERA5_FIRST_DAY);
      neg4_q <= neg_i;
    end
    if (en_i[1]) begin
      doe5_q <= doe4_q;
      a5_q   <= prod_a[edt_pkg::Q1460_SHIFT +: 7];
      b5_q   <= b5_d;
      c5_q   <= (doe4_q == edt_pkg::LAST_ERA_DAY);
      era5_q <= era4_q;
      neg5_q <= neg4_q;
    end
    if (en_i[2]) begin
      n6_q   <= doe5_q - 18'(a5_q) + 18'(b5_q) - 18'(c5_q);
      doe6_q <= doe5_q;
      era6_q <= era5_q;
      neg6_q <= neg5_q;
    end
    if (en_i[3]) begin
      yoe7_q <= prod_y[edt_pkg::Q365_SHIFT +: 9];
      doe7_q <= doe6_q;
      era7_q <= era6_q;
      neg7_q <= neg6_q;
    end
    if (en_i[4]) begin
      doy8_q <= 9'(doe7_q - base);
      yoe8_q <= yoe7_q;
      era8_q <= era7_q;
      neg8_q <= neg7_q;
    end
    if (en_i[5]) begin
      mp9_q  <= prod_m[edt_pkg::Q153_SHIFT +: 4];
      doy9_q <= doy8_q;
      yoe9_q <= yoe8_q;
      era9_q <= era8_q;
      neg9_q <= neg8_q;
    end
    if (en_i[6]) begin
      date_q <= date_d;
    end
  end

  assign date_o = date_q;

endmodule

/* rtl/epoch1900_to_packed_dos_datetime.sv */
// ----------------------------------------------------------------------------
// epoch1900_to_packed_dos_datetime - time-protocol timestamp to DOS words
// Throughput: one transaction per cycle; stalls hold only the stages that are full.
// Reset clears all stage valid bits and sets the hour offset to zero.
// ----------------------------------------------------------------------------
// The converter is a twelve stage pipeline. Stage 0 removes the 1900-to-1970
// epoch gap. The split section adds the configured offset and divides by the
// length of a day, the civil section turns the day count into a Gregorian
// date while the time-of-day section builds the DOS time word in parallel,
// and the output stage packs both words, forcing them to zero whenever the
// date falls outside 1980 to 2107 or the offset pushes the time before 1970.
//
// Every stage has a valid bit. A stage may load when it is empty or when the
// stage after it loads in the same cycle, so bubbles are squeezed out and new
// transactions keep entering while a finished result waits at the output.
module epoch1900_to_packed_dos_datetime (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wen_i,
  input  logic [4:0]  cfg_wdata_i,      // hour_offset, signed
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] raw_time
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] dos_time, [31:16] dos_date
  output logic        m_axis_tuser_o    // [0] out_of_range
);

  localparam int unsigned NS = edt_pkg::NUM_STAGES;

  logic [NS-1:0]      vld_q;
  logic [NS-1:0]      en;
  logic signed [16:0] offs_d, offs_q;
  logic [31:0]        unix_q;
  edt_pkg::split_t    split;
  edt_pkg::date_t     date;
  logic [15:0]        time_word;
  logic [15:0]        dos_time_q, dos_date_q;
  logic               oor_q;

  // A stage loads when it, or any stage downstream of it, is empty, or when
  // the output transaction completes.
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = m_axis_tready_i || !(&(vld_q | NS'((64'd1 << k) - 64'd1)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[edt_pkg::ST_UNIX]) begin
        vld_q[edt_pkg::ST_UNIX] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // The offset is kept in seconds, so the pipeline only sees an addition.
  assign offs_d = 17'(signed'(cfg_wdata_i)) * edt_pkg::SECS_PER_HOUR_S;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_q <= '0;
    end else if (cfg_wen_i) begin
      offs_q <= offs_d;
    end
  end

  // Stage 0: seconds since 1970, wrapping modulo 2^32 like the protocol.
  always_ff @(posedge clk_i) begin
    if (en[edt_pkg::ST_UNIX]) begin
      unix_q <= s_axis_tdata_i - edt_pkg::EPOCH_GAP;
    end
  end

  edt_split u_split (
    .clk_i   (clk_i),
    .en_i    (en[edt_pkg::ST_SPLIT_LO +: edt_pkg::SPLIT_STAGES]),
    .unix_i  (unix_q),
    .offs_i  (offs_q),
    .split_o (split)
  );

  edt_civil u_civil (
    .clk_i  (clk_i),
    .en_i   (en[edt_pkg::ST_CIV_LO +: edt_pkg::CIV_STAGES]),
    .days_i (split.days),
    .neg_i  (split.neg),
    .date_o (date)
  );

  edt_tod u_tod (
    .clk_i       (clk_i),
    .en_i        (en[edt_pkg::ST_CIV_LO +: edt_pkg::CIV_STAGES]),
    .sod_i       (split.sod),
    .time_word_o (time_word)
  );

  // Output stage: both words read as zero when the date cannot be encoded.
  always_ff @(posedge clk_i) begin
    if (en[edt_pkg::ST_OUT]) begin
      oor_q      <= date.oor;
      dos_time_q <= date.oor ? 16'd0 : time_word;
      dos_date_q <= date.oor ? 16'd0 : {date.year_off, date.month, date.day};
    end
  end

  assign s_axis_tready_o = en[edt_pkg::ST_UNIX];
  assign m_axis_tvalid_o = vld_q[edt_pkg::ST_OUT];
  assign m_axis_tdata_o  = {dos_date_q, dos_time_q};
  assign m_axis_tuser_o  = oor_q;

  // An out-of-range result carries all-zero words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 32'd0))
    else $error("out-of-range result with nonzero words");

  // With nothing waiting at the output the pipeline can always take input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while output stage is empty");

  // A valid in-range result holds a legal date and time of day.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |->
      (m_axis_tdata_o[24:21] >= 4'd1 && m_axis_tdata_o[24:21] <= 4'd12 &&
       m_axis_tdata_o[20:16] != 5'd0 && m_axis_tdata_o[15:11] <= 5'd23 &&
       m_axis_tdata_o[10:5] <= 6'd59 && m_axis_tdata_o[4:0] <= 5'd29))
    else $error("illegal date or time in result");

endmodule

/* tb/epoch1900_to_packed_dos_datetime_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch1900_to_packed_dos_datetime_tb - self-checking bench for the DOS packer
// Streams time-protocol timestamps through the converter under several hour
// offsets. A local predictor works out the DOS time and date words and the
// out-of-range flag for every accepted transaction, and a monitor compares
// the results in order while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module epoch1900_to_packed_dos_datetime_tb;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned NUM_PHASES       = 8;
  localparam int unsigned RANDOM_PER_PHASE = 188;
  localparam int unsigned DRAIN_CYCLES     = 20;

  // Raw stamp of 1970-01-01 00:00; subtracting it gives Unix seconds mod 2^32.
  localparam logic [31:0] UNIX_EPOCH_RAW = 32'd2208988800;
  // Raw stamps of a few calendar landmarks (all at 00:00:00 UTC).
  localparam logic [31:0] RAW_1980_JAN_01 = 32'd2524521600;
  localparam logic [31:0] RAW_2000_FEB_29 = 32'd3160771200;
  localparam logic [31:0] RAW_2100_MAR_01 = 32'd2021563904;

  // Hour offsets per phase. The last phase picks a random offset instead.
  localparam int PHASE_HOURS [NUM_PHASES] = '{0, -12, 14, -16, 15, -1, 1, 0};

  typedef struct packed {
    logic [15:0] dos_date;
    logic [15:0] dos_time;
    logic        out_of_range;
  } dos_stamp_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_wen_i       = 1'b0;
  logic [4:0]  cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;    // [31:0] raw_time
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;          // [15:0] dos_time, [31:16] dos_date
  logic        m_axis_tuser_o;          // [0] out_of_range

  // Timestamps still to be sent, and the converted words still owed by the DUT.
  logic [31:0]       pending_stamps[$];
  dos_stamp_t        expected_words[$];
  logic signed [4:0] hour_offset_q = '0;
  int unsigned       fail_count    = 0;
  int unsigned       cycle_count   = 0;

  epoch1900_to_packed_dos_datetime i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wen_i       (cfg_wen_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Converts a raw stamp under the given hour offset into the DOS words. The
  // day count is turned into a civil date with years starting in March, so
  // the leap day is the last day of its year and the month table is regular.
  function automatic dos_stamp_t convert_timestamp(input logic [31:0]       raw,
                                                   input logic signed [4:0] hours);
    dos_stamp_t  res;
    logic [31:0] unix_secs;
    longint      adj, days, sod, shifted, era, doe, yoe, doy, mp, year, month, mday;
    longint      hh, mm, ss;
    res              = '0;
    res.out_of_range = 1'b1;
    unix_secs        = raw - UNIX_EPOCH_RAW;
    adj              = longint'(unix_secs) + longint'(hours) * 3600;
    if (adj < 0) begin
      return res;
    end
    days    = adj / 86400;
    sod     = adj % 86400;
    shifted = days + 719468;
    era     = shifted / 146097;
    doe     = shifted - era * 146097;
    yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy     = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp      = (5 * doy + 2) / 153;
    mday    = doy - (153 * mp + 2) / 5 + 1;
    month   = (mp < 10) ? mp + 3 : mp - 9;
    year    = yoe + era * 400 + ((month <= 2) ? 1 : 0);
    if (year < 1980 || year > 2107) begin
      return res;
    end
    hh               = sod / 3600;
    mm               = (sod % 3600) / 60;
    ss               = sod % 60;
    res.dos_time     = {5'(hh), 6'(mm), 5'(ss / 2)};
    res.dos_date     = {7'(year - 1980), 4'(month), 5'(mday)};
    res.out_of_range = 1'b0;
    return res;
  endfunction

  // Sender: bursts of random length separated by random gaps. A burst of up
  // to 41 items with no gap gives long back-to-back stretches. The expected
  // words are computed the moment a transaction is accepted.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      burst_left       = 0;
      gap_left         = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_words.push_back(convert_timestamp(s_axis_tdata_i, hour_offset_q));
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          s_axis_tvalid_i <= 1'b0;
          gap_left--;
        end else if (pending_stamps.size() > 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pending_stamps.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: switches between always ready, light random stalls, a fixed
  // periodic stall and heavy random stalls, each for a random stretch.
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned rx_tick    = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_mode       = 0;
      mode_left        = 0;
      rx_tick          = 0;
    end else begin
      rx_tick++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= ($urandom_range(0, 9) < 7);
        2:       m_axis_tready_i <= ((rx_tick % 7) > 2);
        default: m_axis_tready_i <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Monitor: every output transaction must match the oldest expectation.
  dos_stamp_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output transaction: tdata=%h tuser=%b",
               m_axis_tdata_o, m_axis_tuser_o);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata_o[15:0] !== want.dos_time) begin
          $error("dos_time mismatch: expected %h, actual %h",
                 want.dos_time, m_axis_tdata_o[15:0]);
          fail_count++;
        end
        if (m_axis_tdata_o[31:16] !== want.dos_date) begin
          $error("dos_date mismatch: expected %h, actual %h",
                 want.dos_date, m_axis_tdata_o[31:16]);
          fail_count++;
        end
        if (m_axis_tuser_o !== want.out_of_range) begin
          $error("out_of_range mismatch: expected %b, actual %b",
                 want.out_of_range, m_axis_tuser_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog against a hung pipeline or handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus sequencing: reset, then one phase per hour offset. The offset is
  // only rewritten once the pipeline has fully drained, since it is applied
  // to every transaction in flight.
  initial begin
    logic signed [4:0] hours;
    logic [31:0]       zero_point;
    logic [31:0]       raw;
    int                shift;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      while (pending_stamps.size() != 0 || s_axis_tvalid_i || expected_words.size() != 0) begin
        @(negedge clk_i);
      end
      hours = (p == NUM_PHASES - 1) ? 5'($urandom_range(0, 31)) : 5'(PHASE_HOURS[p]);
      @(posedge clk_i);
      cfg_wen_i     <= 1'b1;
      cfg_wdata_i   <= hours;
      hour_offset_q  = hours;
      @(posedge clk_i);
      cfg_wen_i <= 1'b0;
      // Fill away from the clock edge so the sender never sees a half-built phase.
      @(negedge clk_i);

      if (p == 0) begin
        // Field extremes, epoch wrap, the 1980 boundary, odd and last seconds
        // of a day, and leap-year corners.
        pending_stamps.push_back(32'h0000_0000);
        pending_stamps.push_back(32'hFFFF_FFFF);
        pending_stamps.push_back(32'h8000_0000);
        pending_stamps.push_back(32'h7FFF_FFFF);
        pending_stamps.push_back(32'hAAAA_AAAA);
        pending_stamps.push_back(32'h5555_5555);
        pending_stamps.push_back(UNIX_EPOCH_RAW);
        pending_stamps.push_back(UNIX_EPOCH_RAW - 32'd1);
        pending_stamps.push_back(UNIX_EPOCH_RAW + 32'd1);
        pending_stamps.push_back(RAW_1980_JAN_01);
        pending_stamps.push_back(RAW_1980_JAN_01 - 32'd1);
        pending_stamps.push_back(RAW_1980_JAN_01 + 32'd1);
        pending_stamps.push_back(RAW_1980_JAN_01 + 32'd86399);
        pending_stamps.push_back(RAW_2000_FEB_29);
        pending_stamps.push_back(RAW_2000_FEB_29 - 32'd1);
        pending_stamps.push_back(RAW_2100_MAR_01);
        pending_stamps.push_back(RAW_2100_MAR_01 - 32'd1);
      end

      // Points where the offset moves the stamp across 1970 or across 1980.
      shift      = -int'(hours) * 3600;
      zero_point = UNIX_EPOCH_RAW + 32'(shift);
      pending_stamps.push_back(zero_point);
      pending_stamps.push_back(zero_point - 32'd1);
      pending_stamps.push_back(RAW_1980_JAN_01 + 32'(shift));
      pending_stamps.push_back(RAW_1980_JAN_01 + 32'(shift) - 32'd1);
      pending_stamps.push_back(32'hFFFF_FFFF);

      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: raw = $urandom;
          4, 5:       raw = RAW_1980_JAN_01 + 32'($urandom_range(0, 32'h7FFF_FFFF));
          6:          raw = zero_point + 32'($urandom_range(0, 120000)) - 32'd60000;
          7:          raw = RAW_1980_JAN_01 + 32'($urandom_range(0, 120000)) - 32'd60000;
          8:          raw = 32'($urandom_range(0, 120000)) - 32'd60000;
          default: begin
            // Near a midnight, which also lands on month and year ends.
            raw = RAW_1980_JAN_01 + 32'($urandom_range(0, 46000)) * 32'd86400
                  + 32'($urandom_range(0, 2)) - 32'd1;
          end
        endcase
        pending_stamps.push_back(raw);
      end
    end

    while (pending_stamps.size() != 0 || s_axis_tvalid_i || expected_words.size() != 0) begin
      @(negedge clk_i);
    end
    // Let any stray output beyond the expected ones show up.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
